// ===== hdl/bir_pkg.sv =====
// Shared types, register indexes and constants for the bilinear image rotator.
// No dependencies; every other file of the block imports this package.
package bir_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  localparam int PIX_W    = 32;
  localparam int CH_W     = 8;
  localparam int NUM_CH   = PIX_W / CH_W;
  localparam int IDX_W    = 12;   // row and column indexes of the banks
  localparam int IN_DATA_W = 72;  // 68 bits of fields padded to whole bytes

  localparam int SIZE_RESET = 256;
  localparam logic signed [15:0] COS_RESET = 16'sd16384;
  localparam logic [17:0] RND_BIAS = 18'd128;
  localparam logic [4:0]  ONE_Q4   = 5'd16;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_QUERY = 1'b1
  } req_t;

  typedef enum logic [2:0] {
    REG_SRC_WIDTH   = 3'd0,
    REG_SRC_HEIGHT  = 3'd1,
    REG_SRC_PIVOT_X = 3'd2,
    REG_SRC_PIVOT_Y = 3'd3,
    REG_DST_PIVOT_X = 3'd4,
    REG_DST_PIVOT_Y = 3'd5,
    REG_NEG_SIN     = 3'd6,
    REG_COS         = 3'd7
  } cfg_reg_t;

  // Width and height are held already clipped to the store size.
  typedef struct packed {
    logic [8:0]         src_width;
    logic [8:0]         src_height;
    logic signed [10:0] src_pivot_x;
    logic signed [10:0] src_pivot_y;
    logic signed [10:0] dst_pivot_x;
    logic signed [10:0] dst_pivot_y;
    logic signed [15:0] neg_sin_q14;
    logic signed [15:0] cos_q14;
  } cfg_t;

  // One access of the two row banks; a write and a read never come together.
  typedef struct packed {
    logic             we;
    logic             w_odd;
    logic [IDX_W-1:0] wrow;
    logic [IDX_W-1:0] wcol;
    logic [PIX_W-1:0] wdata;
    logic             re;
    logic [IDX_W-1:0] erow;
    logic [IDX_W-1:0] orow;
    logic [IDX_W-1:0] col0;
    logic [IDX_W-1:0] col1;
  } mem_req_t;

  // Weights: 0 top-left, 1 top-right, 2 bottom-left, 3 bottom-right.
  typedef struct packed {
    logic            vld;
    logic            outside;
    logic            row_odd;
    logic            has_r;
    logic            has_b;
    logic [3:0][8:0] wgt;
  } blend_ctl_t;

endpackage

// ===== hdl/bir_bank.sv =====
// One row bank of the source image: one write port and two read ports,
// read data registered. Depends on bir_pkg.
module bir_bank
  import bir_pkg::*;
#(
  parameter int ROWS = DEF_MAX_HEIGHT / 2,
  parameter int COLS = DEF_MAX_WIDTH
) (
  input  logic             clk,
  input  logic             en,
  input  logic             we,
  input  logic [IDX_W-1:0] wrow,
  input  logic [IDX_W-1:0] wcol,
  input  logic [PIX_W-1:0] wdata,
  input  logic             re,
  input  logic [IDX_W-1:0] rrow,
  input  logic [IDX_W-1:0] rcol0,
  input  logic [IDX_W-1:0] rcol1,
  output logic [PIX_W-1:0] rdata0,
  output logic [PIX_W-1:0] rdata1
);

  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW = (COLS > 1) ? $clog2(COLS) : 1;

  logic [PIX_W-1:0] mem [ROWS][COLS];
  logic [PIX_W-1:0] rdata0_r;
  logic [PIX_W-1:0] rdata1_r;

  always_ff @(posedge clk) begin
    if (en && we) begin
      mem[wrow[RW-1:0]][wcol[CW-1:0]] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (en && re) begin
      rdata0_r <= mem[rrow[RW-1:0]][rcol0[CW-1:0]];
      rdata1_r <= mem[rrow[RW-1:0]][rcol1[CW-1:0]];
    end
  end

  assign rdata0 = rdata0_r;
  assign rdata1 = rdata1_r;

endmodule

// ===== hdl/bir_map.sv =====
// Coordinate pipeline: inverse rotation, bounds check, bank addressing and
// bilinear weights. Three register stages. Depends on bir_pkg.
module bir_map
  import bir_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             in_vld,
  input  req_t             in_typ,
  input  logic [7:0]       in_x,
  input  logic [7:0]       in_y,
  input  logic [PIX_W-1:0] in_pix,
  input  logic [9:0]       in_dst_x,
  input  logic [9:0]       in_dst_y,
  input  cfg_t             cfg,
  output mem_req_t         mreq,
  output blend_ctl_t       ctl
);

  // Stage 1: offsets from the destination pivot.
  logic               s1_vld_r, s1_vld_nxt;
  req_t               s1_typ_r;
  logic [7:0]         s1_x_r, s1_y_r;
  logic [PIX_W-1:0]   s1_pix_r;
  logic signed [11:0] s1_dx_r, s1_dy_r, s1_dx_nxt, s1_dy_nxt;
  // Stage 2: rotation products.
  logic               s2_vld_r;
  req_t               s2_typ_r;
  logic [7:0]         s2_x_r, s2_y_r;
  logic [PIX_W-1:0]   s2_pix_r;
  logic signed [27:0] s2_xc_r, s2_ys_r, s2_xs_r, s2_yc_r;
  logic signed [27:0] s2_xc_nxt, s2_ys_nxt, s2_xs_nxt, s2_yc_nxt;
  // Stage 3: source position in 1/16 pixel.
  logic               s3_vld_r;
  req_t               s3_typ_r;
  logic [7:0]         s3_x_r, s3_y_r;
  logic [PIX_W-1:0]   s3_pix_r;
  logic signed [19:0] s3_sx16_r, s3_sy16_r, s3_sx16_nxt, s3_sy16_nxt;
  logic signed [28:0] sum_x, sum_y;

  assign s1_vld_nxt = in_vld;
  assign s1_dx_nxt  = $signed({2'b00, in_dst_x}) - $signed({cfg.dst_pivot_x[10], cfg.dst_pivot_x});
  assign s1_dy_nxt  = $signed({2'b00, in_dst_y}) - $signed({cfg.dst_pivot_y[10], cfg.dst_pivot_y});

  assign s2_xc_nxt = $signed(s1_dx_r) * $signed(cfg.cos_q14);
  assign s2_ys_nxt = $signed(s1_dy_r) * $signed(cfg.neg_sin_q14);
  assign s2_xs_nxt = $signed(s1_dx_r) * $signed(cfg.neg_sin_q14);
  assign s2_yc_nxt = $signed(s1_dy_r) * $signed(cfg.cos_q14);

  // Dropping the low ten bits of a two's complement sum is a floor division.
  assign sum_x = $signed({s2_xc_r[27], s2_xc_r}) - $signed({s2_ys_r[27], s2_ys_r});
  assign sum_y = $signed({s2_xs_r[27], s2_xs_r}) + $signed({s2_yc_r[27], s2_yc_r});
  assign s3_sx16_nxt = $signed({sum_x[28], sum_x[28:10]})
                     + $signed({{5{cfg.src_pivot_x[10]}}, cfg.src_pivot_x, 4'd0});
  assign s3_sy16_nxt = $signed({sum_y[28], sum_y[28:10]})
                     + $signed({{5{cfg.src_pivot_y[10]}}, cfg.src_pivot_y, 4'd0});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= s1_vld_nxt;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_typ_r  <= in_typ;
      s1_x_r    <= in_x;
      s1_y_r    <= in_y;
      s1_pix_r  <= in_pix;
      s1_dx_r   <= s1_dx_nxt;
      s1_dy_r   <= s1_dy_nxt;
      s2_typ_r  <= s1_typ_r;
      s2_x_r    <= s1_x_r;
      s2_y_r    <= s1_y_r;
      s2_pix_r  <= s1_pix_r;
      s2_xc_r   <= s2_xc_nxt;
      s2_ys_r   <= s2_ys_nxt;
      s2_xs_r   <= s2_xs_nxt;
      s2_yc_r   <= s2_yc_nxt;
      s3_typ_r  <= s2_typ_r;
      s3_x_r    <= s2_x_r;
      s3_y_r    <= s2_y_r;
      s3_pix_r  <= s2_pix_r;
      s3_sx16_r <= s3_sx16_nxt;
      s3_sy16_r <= s3_sy16_nxt;
    end
  end

  // Memory stage: decode the position and issue the bank access.
  logic [15:0] ix, iy;
  logic [3:0]  fx, fy;
  logic [4:0]  fxn, fyn;
  logic        out_x, out_y, outside;
  logic        in_range;
  logic [9:0]  w0, w1, w2, w3;
  logic [12:0] x13, y13;
  logic [IDX_W-1:0] iy_p1;

  always_comb begin
    ix  = s3_sx16_r[19:4];
    iy  = s3_sy16_r[19:4];
    fx  = s3_sx16_r[3:0];
    fy  = s3_sy16_r[3:0];
    fxn = ONE_Q4 - {1'b0, fx};
    fyn = ONE_Q4 - {1'b0, fy};
    out_x   = ix[15] || (ix[14:0] >= {6'd0, cfg.src_width});
    out_y   = iy[15] || (iy[14:0] >= {6'd0, cfg.src_height});
    outside = out_x || out_y;
    w0 = {5'd0, fxn} * {5'd0, fyn};
    w1 = {6'd0, fx}  * {5'd0, fyn};
    w2 = {5'd0, fxn} * {6'd0, fy};
    w3 = {6'd0, fx}  * {6'd0, fy};
    x13 = {5'd0, s3_x_r};
    y13 = {5'd0, s3_y_r};
    in_range = (x13 < 13'(MAX_WIDTH)) && (y13 < 13'(MAX_HEIGHT));
    iy_p1 = iy[IDX_W-1:0] + 1'b1;

    mreq.we    = s3_vld_r && (s3_typ_r == REQ_WRITE) && in_range;
    mreq.w_odd = s3_y_r[0];
    mreq.wrow  = {5'd0, s3_y_r[7:1]};
    mreq.wcol  = {4'd0, s3_x_r};
    mreq.wdata = s3_pix_r;
    mreq.re    = s3_vld_r && (s3_typ_r == REQ_QUERY) && !outside;
    // The two neighbouring rows always fall one in each bank.
    mreq.erow  = {1'b0, iy_p1[IDX_W-1:1]};
    mreq.orow  = {1'b0, iy[IDX_W-1:1]};
    mreq.col0  = ix[IDX_W-1:0];
    mreq.col1  = ix[IDX_W-1:0] + 1'b1;

    ctl.vld     = s3_vld_r && (s3_typ_r == REQ_QUERY);
    ctl.outside = outside;
    ctl.row_odd = iy[0];
    ctl.has_r   = ({1'b0, ix[14:0]} + 16'd1) < {7'd0, cfg.src_width};
    ctl.has_b   = ({1'b0, iy[14:0]} + 16'd1) < {7'd0, cfg.src_height};
    ctl.wgt[0]  = w0[8:0];
    ctl.wgt[1]  = w1[8:0];
    ctl.wgt[2]  = w2[8:0];
    ctl.wgt[3]  = w3[8:0];
  end

endmodule

// ===== hdl/bir_blend.sv =====
// Bilinear blend: neighbour selection, weighted products, rounded sum and the
// output register with its stall logic. Depends on bir_pkg.
module bir_blend
  import bir_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  blend_ctl_t       ctl,
  input  logic [PIX_W-1:0] even0,
  input  logic [PIX_W-1:0] even1,
  input  logic [PIX_W-1:0] odd0,
  input  logic [PIX_W-1:0] odd1,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [PIX_W-1:0] out_pixel,
  output logic             out_outside,
  output logic             hold
);

  blend_ctl_t       s4_ctl_r;
  logic [PIX_W-1:0] nb [4];
  logic [15:0]      prod_nxt [NUM_CH][4];
  logic [15:0]      s5_prod_r [NUM_CH][4];
  logic             s5_vld_r;
  logic             s5_out_r;
  logic             out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0] out_pixel_r, out_pixel_nxt;
  logic             out_outside_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_ctl_r <= '0;
    end else if (adv) begin
      s4_ctl_r <= ctl;
    end
  end

  // Neighbours outside the image, or of an outside position, count as zero.
  always_comb begin
    logic m00, m10, m01, m11;
    logic [PIX_W-1:0] top0, top1, bot0, bot1;
    top0 = s4_ctl_r.row_odd ? odd0  : even0;
    top1 = s4_ctl_r.row_odd ? odd1  : even1;
    bot0 = s4_ctl_r.row_odd ? even0 : odd0;
    bot1 = s4_ctl_r.row_odd ? even1 : odd1;
    m00 = !s4_ctl_r.outside;
    m10 = m00 && s4_ctl_r.has_r;
    m01 = m00 && s4_ctl_r.has_b;
    m11 = m10 && s4_ctl_r.has_b;
    nb[0] = m00 ? top0 : '0;
    nb[1] = m10 ? top1 : '0;
    nb[2] = m01 ? bot0 : '0;
    nb[3] = m11 ? bot1 : '0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      for (int k = 0; k < 4; k++) begin
        prod_nxt[ch][k] = {7'd0, s4_ctl_r.wgt[k]} * {8'd0, nb[k][ch*CH_W +: CH_W]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else if (adv) begin
      s5_vld_r <= s4_ctl_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_out_r  <= s4_ctl_r.outside;
      s5_prod_r <= prod_nxt;
    end
  end

  // The four weights add to 256, so the rounded sum never passes 16 bits.
  always_comb begin
    logic [17:0] acc;
    out_pixel_nxt = '0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      acc = {2'd0, s5_prod_r[ch][0]} + {2'd0, s5_prod_r[ch][1]}
          + {2'd0, s5_prod_r[ch][2]} + {2'd0, s5_prod_r[ch][3]} + RND_BIAS;
      out_pixel_nxt[ch*CH_W +: CH_W] = acc[15:8];
    end
  end

  assign hold = out_valid_r && !out_ready && s5_vld_r;

  always_comb begin
    if (adv && s5_vld_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s5_vld_r) begin
      out_pixel_r   <= out_pixel_nxt;
      out_outside_r <= s5_out_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_pixel   = out_pixel_r;
  assign out_outside = out_outside_r;

endmodule

// ===== hdl/bilinear_image_rotator_top.sv =====
// A query's result reaches out_tvalid through the map stages, the bank
// read, the product and output registers. Throughput: one transaction per
// cycle unless the result side stalls, writes and queries mixed freely; the
// rate is set by the two row banks, each serving two reads or one write a cycle.
// Reset: synchronous, active low; clears all valid flags and returns the
// registers to their defaults. The image store is not cleared and needs no pass.
module bilinear_image_rotator_top
  import bir_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Input stream. tdata, from bit 0: src_x[7:0], src_y[15:8],
  // pixel_in[47:16], dst_x[57:48], dst_y[67:58], zero padding [71:68].
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic                 in_tuser,   // req_type: 0 write, 1 query
  // Result stream. tdata: pixel_out[31:0].
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [PIX_W-1:0]     out_tdata,
  output logic                 out_tuser,  // outside flag
  // Register write channel.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data
);

  // The store is split by row parity so that any 2x2 neighbourhood needs
  // exactly two reads from each bank.
  localparam int EVEN_ROWS = (MAX_HEIGHT + 1) / 2;
  localparam int ODD_ROWS  = MAX_HEIGHT / 2;
  localparam logic [8:0] W_RESET = 9'((MAX_WIDTH  < SIZE_RESET) ? MAX_WIDTH  : SIZE_RESET);
  localparam logic [8:0] H_RESET = 9'((MAX_HEIGHT < SIZE_RESET) ? MAX_HEIGHT : SIZE_RESET);

  cfg_t       cfg_r, cfg_nxt;
  logic       adv;
  logic       hold;
  logic       in_accept;
  mem_req_t   mreq;
  blend_ctl_t ctl;
  logic [PIX_W-1:0] even0, even1, odd0, odd1;

  // Register writes. Sizes are clipped to the store dimensions when written,
  // so the query path compares against them directly.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SRC_WIDTH: begin
          cfg_nxt.src_width = ({4'd0, cfg_data[8:0]} > 13'(MAX_WIDTH)) ?
                              9'(MAX_WIDTH) : cfg_data[8:0];
        end
        REG_SRC_HEIGHT: begin
          cfg_nxt.src_height = ({4'd0, cfg_data[8:0]} > 13'(MAX_HEIGHT)) ?
                               9'(MAX_HEIGHT) : cfg_data[8:0];
        end
        REG_SRC_PIVOT_X: cfg_nxt.src_pivot_x = cfg_data[10:0];
        REG_SRC_PIVOT_Y: cfg_nxt.src_pivot_y = cfg_data[10:0];
        REG_DST_PIVOT_X: cfg_nxt.dst_pivot_x = cfg_data[10:0];
        REG_DST_PIVOT_Y: cfg_nxt.dst_pivot_y = cfg_data[10:0];
        REG_NEG_SIN:     cfg_nxt.neg_sin_q14 = cfg_data;
        REG_COS:         cfg_nxt.cos_q14     = cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.src_width   <= W_RESET;
      cfg_r.src_height  <= H_RESET;
      cfg_r.src_pivot_x <= '0;
      cfg_r.src_pivot_y <= '0;
      cfg_r.dst_pivot_x <= '0;
      cfg_r.dst_pivot_y <= '0;
      cfg_r.neg_sin_q14 <= '0;
      cfg_r.cos_q14     <= COS_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_ready = 1'b1;

  // The whole pipeline moves together. It only stops when a finished result
  // sits in the output register, is not taken, and another result is right
  // behind it; empty slots keep flowing so new transactions are still taken.
  assign adv       = !hold;
  assign in_tready = adv;
  assign in_accept = in_tvalid && adv;

  // Writes travel the same pipeline as queries and reach the banks at the
  // same stage, so every query sees exactly the writes accepted before it.
  bir_map #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_map (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (in_accept),
    .in_typ   (req_t'(in_tuser)),
    .in_x     (in_tdata[7:0]),
    .in_y     (in_tdata[15:8]),
    .in_pix   (in_tdata[47:16]),
    .in_dst_x (in_tdata[57:48]),
    .in_dst_y (in_tdata[67:58]),
    .cfg      (cfg_r),
    .mreq     (mreq),
    .ctl      (ctl)
  );

  bir_bank #(
    .ROWS (EVEN_ROWS),
    .COLS (MAX_WIDTH)
  ) u_bank_even (
    .clk    (clk),
    .en     (adv),
    .we     (mreq.we && !mreq.w_odd),
    .wrow   (mreq.wrow),
    .wcol   (mreq.wcol),
    .wdata  (mreq.wdata),
    .re     (mreq.re),
    .rrow   (mreq.erow),
    .rcol0  (mreq.col0),
    .rcol1  (mreq.col1),
    .rdata0 (even0),
    .rdata1 (even1)
  );

  bir_bank #(
    .ROWS (ODD_ROWS),
    .COLS (MAX_WIDTH)
  ) u_bank_odd (
    .clk    (clk),
    .en     (adv),
    .we     (mreq.we && mreq.w_odd),
    .wrow   (mreq.wrow),
    .wcol   (mreq.wcol),
    .wdata  (mreq.wdata),
    .re     (mreq.re),
    .rrow   (mreq.orow),
    .rcol0  (mreq.col0),
    .rcol1  (mreq.col1),
    .rdata0 (odd0),
    .rdata1 (odd1)
  );

  bir_blend u_blend (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .ctl         (ctl),
    .even0       (even0),
    .even1       (even1),
    .odd0        (odd0),
    .odd1        (odd1),
    .out_ready   (out_tready),
    .out_valid   (out_tvalid),
    .out_pixel   (out_tdata),
    .out_outside (out_tuser),
    .hold        (hold)
  );

`ifndef ASSERT_OFF
  // An outside result always carries a zero pixel.
  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == '0))
    else $error("outside result with nonzero pixel");

  // Input back-pressure only comes from a stalled result transaction.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without a blocked result");

  // One pipeline slot holds either a write or a read, never both.
  a_bank_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(mreq.we && mreq.re))
    else $error("bank write and read issued together");

  // A stalled pipeline must not let a held result change.
  a_hold_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    hold |=> $stable(out_tdata))
    else $error("held result changed during a stall");
`endif

endmodule

// ===== tb/bilinear_image_rotator_top_test.sv =====
// Self-checking testbench for bilinear_image_rotator_top: rotated pixel queries
// against a behavioral predictor. Depends only on bir_pkg and the top level.
module bilinear_image_rotator_top_test;
  import bir_pkg::*;

  localparam int MAX_W = DEF_MAX_WIDTH;
  localparam int MAX_H = DEF_MAX_HEIGHT;
  localparam int DST_MAX = 1023;
  // Wait after the results are in; it covers writes still in flight when the last
  // result has already come back.
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT = 200000;

  // One result as the block should present it.
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             outside;
  } rotated_pixel_t;

  // Where a destination pixel lands in the source, in whole pixels plus
  // sixteenths, and which neighbours of the 2x2 footprint exist.
  typedef struct {
    bit outside;
    bit has_r;
    bit has_b;
    int ix;
    int iy;
    int fx;
    int fy;
  } src_pos_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_RANDOM,
    RX_PERIODIC,
    RX_SPARSE
  } rx_mode_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic                 in_tuser = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [PIX_W-1:0]     out_tdata;
  logic                 out_tuser;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [2:0]           cfg_index = '0;
  logic [15:0]          cfg_data = '0;

  // Our own copy of the geometry registers after each write, sizes kept unclipped.
  logic [8:0]         geo_width = 9'd256;
  logic [8:0]         geo_height = 9'd256;
  logic signed [10:0] geo_src_px = '0;
  logic signed [10:0] geo_src_py = '0;
  logic signed [10:0] geo_dst_px = '0;
  logic signed [10:0] geo_dst_py = '0;
  logic signed [15:0] geo_neg_sin = '0;
  logic signed [15:0] geo_cos = COS_RESET;

  // Shadow of the source image and a record of which entries hold real data.
  logic [PIX_W-1:0] image_store [MAX_W*MAX_H];
  bit               pixel_written [MAX_W*MAX_H];

  rotated_pixel_t expected_pixels [$];

  int       items_sent = 0;
  int       mismatch_count = 0;
  int       cycle_count = 0;
  int       burst_left = 0;
  bit       idle_enable = 1'b1;
  logic [6:0] rx_tick = '0;
  rx_mode_t rx_mode = RX_OPEN;

  bilinear_image_rotator_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // src_x, src_y, pixel_in, dst_x, dst_y, padding
    .in_tuser   (in_tuser),   // req_type
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // pixel_out
    .out_tuser  (out_tuser),  // outside
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  // Run guard: a hang anywhere in the handshakes ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // The result side stalls on its own pattern. Whenever its tick counter wraps
  // it switches among always ready, random stalls, one stall in four and ready
  // only one cycle in eight, so backpressure lands on every stage of the pipeline.
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1'b1;
    if (rx_tick == '0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
    end
    case (rx_mode)
      RX_OPEN:     out_tready <= 1'b1;
      RX_RANDOM:   out_tready <= ($urandom_range(0, 9) > 2);
      RX_PERIODIC: out_tready <= (rx_tick[1:0] != 2'd3);
      default:     out_tready <= (rx_tick[2:0] == 3'd0);
    endcase
  end

  // Every result transaction is matched against the oldest expectation.
  // The pixel and the outside flag are compared one by one.
  always @(posedge clk) begin
    rotated_pixel_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual pixel %h outside %b",
                 $time, out_tdata, out_tuser);
        mismatch_count++;
      end else begin
        want = expected_pixels.pop_front();
        if (out_tdata !== want.pixel) begin
          $display("%0t: pixel_out mismatch, expected %h, actual %h",
                   $time, want.pixel, out_tdata);
          mismatch_count++;
        end
        if (out_tuser !== want.outside) begin
          $display("%0t: outside mismatch, expected %b, actual %b",
                   $time, want.outside, out_tuser);
          mismatch_count++;
        end
      end
    end
  end

  // Inverse rotation of one destination pixel. The products are summed at
  // full width and shifted arithmetically, so negative positions round toward
  // minus infinity rather than toward zero.
  function automatic src_pos_t map_to_source(input logic [9:0] qx, input logic [9:0] qy);
    longint w, h, dx, dy, sx16, sy16, ix, iy;
    src_pos_t p;
    w = (geo_width > MAX_W) ? MAX_W : geo_width;
    h = (geo_height > MAX_H) ? MAX_H : geo_height;
    dx = longint'(qx) - longint'(geo_dst_px);
    dy = longint'(qy) - longint'(geo_dst_py);
    sx16 = longint'(geo_src_px) * 16 +
           ((dx * longint'(geo_cos) - dy * longint'(geo_neg_sin)) >>> 10);
    sy16 = longint'(geo_src_py) * 16 +
           ((dx * longint'(geo_neg_sin) + dy * longint'(geo_cos)) >>> 10);
    ix = sx16 >>> 4;
    iy = sy16 >>> 4;
    p.outside = (ix < 0) || (ix >= w) || (iy < 0) || (iy >= h);
    p.has_r = (ix < w - 1);
    p.has_b = (iy < h - 1);
    p.ix = int'(ix);
    p.iy = int'(iy);
    p.fx = int'(sx16 & 15);
    p.fy = int'(sy16 & 15);
    return p;
  endfunction

  // Bilinear blend of the 2x2 footprint; missing right and bottom neighbours
  // count as black.
  function automatic logic [PIX_W-1:0] blend_pixel(input src_pos_t p);
    logic [PIX_W-1:0] p00, p10, p01, p11, res;
    int addr, acc;
    addr = p.iy * MAX_W + p.ix;
    p00 = image_store[addr];
    p10 = p.has_r ? image_store[addr + 1] : '0;
    p01 = p.has_b ? image_store[addr + MAX_W] : '0;
    p11 = (p.has_r && p.has_b) ? image_store[addr + MAX_W + 1] : '0;
    res = '0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      acc = (16 - p.fx) * (16 - p.fy) * int'(p00[ch*CH_W +: CH_W]) +
            p.fx * (16 - p.fy) * int'(p10[ch*CH_W +: CH_W]) +
            (16 - p.fx) * p.fy * int'(p01[ch*CH_W +: CH_W]) +
            p.fx * p.fy * int'(p11[ch*CH_W +: CH_W]);
      res[ch*CH_W +: CH_W] = CH_W'((acc + 128) / 256);
    end
    return res;
  endfunction

  // Random content in every field; callers overwrite the ones that matter.
  function automatic logic [IN_DATA_W-1:0] random_fields();
    logic [IN_DATA_W-1:0] data;
    data[31:0] = $urandom;
    data[63:32] = $urandom;
    data[71:64] = 8'($urandom);
    data[71:68] = '0;
    return data;
  endfunction

  function automatic int clamp_coord(input int v);
    return (v < 0) ? 0 : (v > DST_MAX) ? DST_MAX : v;
  endfunction

  function automatic int pick_size(input int limit);
    case ($urandom_range(0, 19))
      0:       return 0;
      1:       return 1;
      2:       return limit;
      3, 4:    return $urandom_range(limit + 1, 511);
      5, 6, 7: return $urandom_range(17, limit);
      default: return $urandom_range(2, 16);
    endcase
  endfunction

  // Sends one input transaction. The sender runs in bursts with random gaps
  // between them; valid is never dropped and raised within the same step.
  // On acceptance the shadow image is updated or the result is predicted.
  task automatic send_item(input req_t kind, input logic [IN_DATA_W-1:0] data);
    int gap;
    int addr;
    src_pos_t p;
    rotated_pixel_t res;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = (idle_enable && ($urandom_range(0, 3) != 0)) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (kind == REQ_WRITE) begin
      addr = int'(data[15:8]) * MAX_W + int'(data[7:0]);
      image_store[addr] = data[47:16];
      pixel_written[addr] = 1'b1;
    end else begin
      p = map_to_source(data[57:48], data[67:58]);
      res.outside = p.outside;
      res.pixel = p.outside ? '0 : blend_pixel(p);
      expected_pixels.insert(expected_pixels.size(), res);
    end
    items_sent++;
  endtask

  task automatic send_write(input int x, input int y, input logic [PIX_W-1:0] pix);
    logic [IN_DATA_W-1:0] data;
    data = random_fields();
    data[7:0] = 8'(x);
    data[15:8] = 8'(y);
    data[47:16] = pix;
    send_item(REQ_WRITE, data);
  endtask

  // Makes sure every entry of the footprint that exists in the store holds
  // written data before the query that reads it goes out.
  task automatic prime_footprint(input src_pos_t p);
    int x, y;
    for (int yo = 0; yo < 2; yo++) begin
      for (int xo = 0; xo < 2; xo++) begin
        x = p.ix + xo;
        y = p.iy + yo;
        if (x < MAX_W && y < MAX_H && !pixel_written[y*MAX_W + x]) begin
          send_write(x, y, $urandom);
        end
      end
    end
  endtask

  task automatic send_query(input int qx, input int qy);
    logic [IN_DATA_W-1:0] data;
    src_pos_t p;
    p = map_to_source(10'(qx), 10'(qy));
    if (!p.outside) begin
      prime_footprint(p);
    end
    data = random_fields();
    data[57:48] = 10'(qx);
    data[67:58] = 10'(qy);
    send_item(REQ_QUERY, data);
  endtask

  // Stops the sender until every expected result has arrived, then lets the
  // pipeline empty of writes too.
  task automatic wait_results_done();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_SRC_WIDTH:   geo_width = value[8:0];
      REG_SRC_HEIGHT:  geo_height = value[8:0];
      REG_SRC_PIVOT_X: geo_src_px = value[10:0];
      REG_SRC_PIVOT_Y: geo_src_py = value[10:0];
      REG_DST_PIVOT_X: geo_dst_px = value[10:0];
      REG_DST_PIVOT_Y: geo_dst_py = value[10:0];
      REG_NEG_SIN:     geo_neg_sin = value;
      REG_COS:         geo_cos = value;
      default: ;
    endcase
  endtask

  // Writes all eight registers back to back. The bits above each register's
  // width carry random junk, which the block has to ignore.
  task automatic set_config(input int w, input int h, input int spx, input int spy,
                            input int dpx, input int dpy, input int nsin, input int cs);
    logic [15:0] junk;
    junk = 16'($urandom);
    write_reg(REG_SRC_WIDTH, {junk[15:9], 9'(w)});
    write_reg(REG_SRC_HEIGHT, {junk[15:9], 9'(h)});
    write_reg(REG_SRC_PIVOT_X, {junk[15:11], 11'(spx)});
    write_reg(REG_SRC_PIVOT_Y, {junk[15:11], 11'(spy)});
    write_reg(REG_DST_PIVOT_X, {junk[15:11], 11'(dpx)});
    write_reg(REG_DST_PIVOT_Y, {junk[15:11], 11'(dpy)});
    write_reg(REG_NEG_SIN, 16'(nsin));
    write_reg(REG_COS, 16'(cs));
    cfg_valid <= 1'b0;
  endtask

  // Reset geometry is the identity map over a full 256x256 source. Corner
  // pixels with extreme values, plus queries just past the edge and at the
  // far corner of the destination range.
  task automatic test_identity_defaults();
    send_write(0, 0, 32'hffff_ffff);
    send_write(1, 1, 32'h0000_0000);
    send_write(MAX_W - 1, MAX_H - 1, 32'h1234_5678);
    send_query(0, 0);
    send_query(MAX_W - 1, MAX_H - 1);
    send_query(MAX_W, 0);
    send_query(DST_MAX, DST_MAX);
  endtask

  // A 3x2 source at half scale: half-pixel weights, a full four-neighbour
  // blend, the right and bottom edges where neighbours drop out, and the
  // first column past the right edge.
  task automatic test_edge_blend();
    wait_results_done();
    set_config(3, 2, 0, 0, 0, 0, 0, 8192);
    send_write(1, 0, 32'h00ff_807f);
    send_write(0, 1, 32'h01fe_0180);
    send_query(1, 1);
    send_query(4, 2);
    send_query(5, 3);
    send_query(6, 0);
  endtask

  // A tiny cosine against a pivot at the far corner gives offsets of just
  // below zero: the position must floor to the pixel before, leaving weights
  // of fifteen sixteenths.
  task automatic test_floor_rounding();
    wait_results_done();
    set_config(2, 2, 1, 1, DST_MAX, DST_MAX, 0, 1);
    send_query(0, 0);
    send_query(1022, 1023);
    send_query(1023, 1023);
  endtask

  // Size zero makes every query fall outside; sizes beyond the store clip to
  // it; extreme pivots and rotation terms throw the map far out.
  task automatic test_size_limits();
    wait_results_done();
    set_config(0, 5, 0, 0, 0, 0, 0, 16384);
    send_query(0, 0);
    wait_results_done();
    set_config(511, 300, 0, 0, 0, 0, 0, 16384);
    send_query(MAX_W - 1, MAX_H - 1);
    send_query(MAX_W - 1, 0);
    send_query(MAX_W, 3);
    wait_results_done();
    set_config(2, 2, -1024, 1023, -1024, -1024, -32768, 32767);
    send_query(0, 0);
    send_query(DST_MAX, DST_MAX);
  endtask

  // Random geometry per phase. Most queries land near the destination pivot
  // so they map into the image and exercise the blend; the rest are stray
  // queries anywhere and writes anywhere in the store. One phase runs the
  // sender without gaps. Each phase ends with the sender paused until every
  // result has come back, which is also when the registers may change.
  task automatic test_random_rotations();
    int w, h, wsat, hsat, span, spx, spy, dpx, dpy, nsin, cs, phase_end, a;
    for (int phase = 0; phase < 6; phase++) begin
      w = pick_size(MAX_W);
      h = pick_size(MAX_H);
      wsat = (w > MAX_W) ? MAX_W : w;
      hsat = (h > MAX_H) ? MAX_H : h;
      span = ((wsat > hsat) ? wsat : hsat) + 2;
      spx = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2047) - 1024 : wsat / 2;
      spy = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2047) - 1024 : hsat / 2;
      dpx = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2047) - 1024 :
                                          $urandom_range(0, DST_MAX);
      dpy = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2047) - 1024 :
                                          $urandom_range(0, DST_MAX);
      case ($urandom_range(0, 9))
        0: begin
          nsin = 0;
          cs = 16384;
        end
        1: begin
          nsin = 16384;
          cs = 0;
        end
        2: begin
          nsin = 0;
          cs = -16384;
        end
        3: begin
          nsin = -11585;
          cs = 11585;
        end
        4: begin
          nsin = $urandom_range(0, 65535) - 32768;
          cs = $urandom_range(0, 65535) - 32768;
        end
        default: begin
          nsin = $urandom_range(0, 32768) - 16384;
          cs = $urandom_range(0, 32768) - 16384;
        end
      endcase
      wait_results_done();
      set_config(w, h, spx, spy, dpx, dpy, nsin, cs);
      idle_enable = (phase != 1);
      phase_end = items_sent + 75;
      while (items_sent < phase_end) begin
        a = $urandom_range(0, 99);
        if (a < 12) begin
          send_write($urandom_range(0, MAX_W - 1), $urandom_range(0, MAX_H - 1), $urandom);
        end else if (a < 22) begin
          send_query($urandom_range(0, DST_MAX), $urandom_range(0, DST_MAX));
        end else begin
          send_query(clamp_coord(dpx + $urandom_range(0, 2 * span) - span),
                     clamp_coord(dpy + $urandom_range(0, 2 * span) - span));
        end
      end
    end
    idle_enable = 1'b1;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_identity_defaults();
    test_edge_blend();
    test_floor_rounding();
    test_size_limits();
    test_random_rotations();
    // Drain every outstanding result; the run guard bounds this wait.
    wait_results_done();
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
